// File: rtl/core/pba_pkg.sv
// ----------------------------------------------------------------------------
// Page bitmap allocator package
// Shared constants, request/result payload types and the command/status
// structs between the controller and the datapath.
// ----------------------------------------------------------------------------
package pba_pkg;

  // Default geometry
  localparam int NumPagesDef = 1024;
  localparam int PageSizeDef = 4096;

  // Bitmap memory word: 32 pages per word
  localparam int WordW = 32;
  localparam int BitW  = 5;

  // Configuration register widths and reset values
  localparam int AddrW = 32;
  localparam int PageCfgW = 11;
  localparam logic [AddrW-1:0]    BaseAddrRst  = 32'h0010_0000;
  localparam logic [PageCfgW-1:0] RsvPagesRst  = 11'd256;
  localparam logic [PageCfgW-1:0] HeapFirstRst = 11'd256;
  localparam logic [PageCfgW-1:0] HeapEndRst   = 11'd512;

  // Configuration register indexes
  localparam int CfgIdxW = 2;
  localparam logic [CfgIdxW-1:0] CfgBaseAddr  = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgRsvPages  = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgHeapFirst = 2'd2;
  localparam logic [CfgIdxW-1:0] CfgHeapEnd   = 2'd3;

  // Request codes
  localparam logic [1:0] ReqAlloc = 2'd0;
  localparam logic [1:0] ReqFree  = 2'd1;
  localparam logic [1:0] ReqInit  = 2'd2;

  // Result status codes
  localparam logic [1:0] StOk    = 2'd0;
  localparam logic [1:0] StOom   = 2'd1;
  localparam logic [1:0] StRange = 2'd2;

  // Result select codes (controller -> datapath)
  localparam logic [1:0] ResOk    = 2'd0;
  localparam logic [1:0] ResAlloc = 2'd1;
  localparam logic [1:0] ResOom   = 2'd2;
  localparam logic [1:0] ResRange = 2'd3;

  typedef struct packed {
    logic [1:0]       req_type;
    logic [AddrW-1:0] free_address;
  } req_t;

  typedef struct packed {
    logic [AddrW-1:0] page_address;
    logic [1:0]       status;
  } res_t;

  // Controller -> datapath commands
  typedef struct packed {
    logic       accept;    // request transfer this cycle
    logic       snap;      // capture init bounds
    logic       cnt_clr;   // clear word counter
    logic       cnt_inc;   // advance word counter
    logic       scan;      // scan read at word counter
    logic       rd_free;   // read word of the page to free
    logic       wr_init;   // write init pattern at word counter
    logic       wr_alloc;  // clear found bit in checked word
    logic       wr_free;   // set bit of freed page
    logic       emit;      // load result register and strobe
    logic [1:0] res_sel;
  } dp_cmd_t;

  // Datapath -> controller status
  typedef struct packed {
    logic is_alloc;
    logic is_free;
    logic is_init;
    logic hit;         // checked scan word holds a free page
    logic chk_last;    // checked scan word is the last word
    logic chk_valid;   // a scan word is checked this cycle
    logic cnt_last;    // word counter at last word
    logic free_range;  // pending free address is out of range
  } dp_sts_t;

endpackage

// File: rtl/core/pba_ctrl.sv
// ----------------------------------------------------------------------------
// Page bitmap allocator controller
// Sequences init sweeps, allocation scans and free read-modify-writes.
// ----------------------------------------------------------------------------
module pba_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start,
  output logic             busy,
  input  pba_pkg::dp_sts_t sts_i,
  output pba_pkg::dp_cmd_t cmd_o
);

  localparam logic [2:0] StInit   = 3'd0;
  localparam logic [2:0] StIdle   = 3'd1;
  localparam logic [2:0] StScan   = 3'd2;
  localparam logic [2:0] StFreeRd = 3'd3;
  localparam logic [2:0] StFreeWr = 3'd4;

  logic [2:0] state_q, state_d;
  logic       reply_q, reply_d;

  // State registers; reset starts the bitmap init sweep without a reply
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StInit;
      reply_q <= 1'b0;
    end else begin
      state_q <= state_d;
      reply_q <= reply_d;
    end
  end

  assign busy = (state_q != StIdle);

  // Next state and commands
  always_comb begin
    state_d = state_q;
    reply_d = reply_q;
    cmd_o   = '0;
    unique case (state_q)
      StIdle: begin
        if (start) begin
          cmd_o.accept  = 1'b1;
          cmd_o.cnt_clr = 1'b1;
          if (sts_i.is_alloc) begin
            state_d = StScan;
          end else if (sts_i.is_free) begin
            state_d = StFreeRd;
          end else if (sts_i.is_init) begin
            cmd_o.snap = 1'b1;
            reply_d    = 1'b1;
            state_d    = StInit;
          end else begin
            // unused request code: plain ok reply
            cmd_o.emit    = 1'b1;
            cmd_o.res_sel = pba_pkg::ResOk;
          end
        end
      end
      StScan: begin
        cmd_o.scan    = 1'b1;
        cmd_o.cnt_inc = 1'b1;
        if (sts_i.hit) begin
          cmd_o.wr_alloc = 1'b1;
          cmd_o.emit     = 1'b1;
          cmd_o.res_sel  = pba_pkg::ResAlloc;
          state_d        = StIdle;
        end else if (sts_i.chk_valid && sts_i.chk_last) begin
          cmd_o.emit    = 1'b1;
          cmd_o.res_sel = pba_pkg::ResOom;
          state_d       = StIdle;
        end
      end
      StFreeRd: begin
        if (sts_i.free_range) begin
          cmd_o.emit    = 1'b1;
          cmd_o.res_sel = pba_pkg::ResRange;
          state_d       = StIdle;
        end else begin
          cmd_o.rd_free = 1'b1;
          state_d       = StFreeWr;
        end
      end
      StFreeWr: begin
        cmd_o.wr_free = 1'b1;
        cmd_o.emit    = 1'b1;
        cmd_o.res_sel = pba_pkg::ResOk;
        state_d       = StIdle;
      end
      StInit: begin
        cmd_o.wr_init = 1'b1;
        cmd_o.cnt_inc = 1'b1;
        if (sts_i.cnt_last) begin
          state_d = StIdle;
          reply_d = 1'b0;
          if (reply_q) begin
            cmd_o.emit    = 1'b1;
            cmd_o.res_sel = pba_pkg::ResOk;
          end
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

endmodule

// File: rtl/core/pba_dp.sv
// ----------------------------------------------------------------------------
// Page bitmap allocator datapath
// Config registers, bitmap memory (32 pages per word), word counter,
// first-free search, address arithmetic and the result register.
// ----------------------------------------------------------------------------
module pba_dp #(
  parameter int NUM_PAGES = pba_pkg::NumPagesDef,
  parameter int PAGE_SIZE = pba_pkg::PageSizeDef
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [pba_pkg::CfgIdxW-1:0]     cfg_idx_i,
  input  logic [pba_pkg::AddrW-1:0]       cfg_data_i,
  input  pba_pkg::req_t                   req_i,
  input  pba_pkg::dp_cmd_t                cmd_i,
  output pba_pkg::dp_sts_t                sts_o,
  output pba_pkg::res_t                   res_o,
  output logic                            res_valid_o
);

  localparam int WordW   = pba_pkg::WordW;
  localparam int BitW    = pba_pkg::BitW;
  localparam int AW      = pba_pkg::AddrW;
  localparam int PCW     = pba_pkg::PageCfgW;
  localparam int Depth   = (NUM_PAGES + WordW - 1) / WordW;
  localparam int WA      = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int PsShift = $clog2(PAGE_SIZE);
  localparam int CW      = (WA + BitW > PCW) ? (WA + BitW) : PCW;
  localparam int Rem     = NUM_PAGES % WordW;
  localparam logic [WA-1:0]    LastWord = WA'(Depth - 1);
  localparam logic [WordW-1:0] TailMask =
    (Rem == 0) ? {WordW{1'b1}} : ({WordW{1'b1}} >> (WordW - Rem));

  // Configuration registers
  logic [AW-1:0]  base_q;
  logic [PCW-1:0] rsv_q, hfirst_q, hend_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q   <= pba_pkg::BaseAddrRst;
      rsv_q    <= pba_pkg::RsvPagesRst;
      hfirst_q <= pba_pkg::HeapFirstRst;
      hend_q   <= pba_pkg::HeapEndRst;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        pba_pkg::CfgBaseAddr:  base_q   <= cfg_data_i;
        pba_pkg::CfgRsvPages:  rsv_q    <= cfg_data_i[PCW-1:0];
        pba_pkg::CfgHeapFirst: hfirst_q <= cfg_data_i[PCW-1:0];
        pba_pkg::CfgHeapEnd:   hend_q   <= cfg_data_i[PCW-1:0];
        default: ;
      endcase
    end
  end

  // Init bounds, captured when a sweep starts
  logic [PCW-1:0] i_rsv_q, i_hfirst_q, i_hend_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      i_rsv_q    <= pba_pkg::RsvPagesRst;
      i_hfirst_q <= pba_pkg::HeapFirstRst;
      i_hend_q   <= pba_pkg::HeapEndRst;
    end else if (cmd_i.snap) begin
      i_rsv_q    <= rsv_q;
      i_hfirst_q <= hfirst_q;
      i_hend_q   <= hend_q;
    end
  end

  // Request decode
  assign sts_o.is_alloc = (req_i.req_type == pba_pkg::ReqAlloc);
  assign sts_o.is_free  = (req_i.req_type == pba_pkg::ReqFree);
  assign sts_o.is_init  = (req_i.req_type == pba_pkg::ReqInit);

  // Free address to page index, captured at the request transfer
  logic [AW-1:0]   diff;
  logic [AW-1:0]   pg_full;
  logic            range_d;
  logic            frange_q;
  logic [WA-1:0]   fword_q;
  logic [BitW-1:0] fbit_q;

  assign diff    = req_i.free_address - base_q;
  assign pg_full = diff >> PsShift;
  assign range_d = (req_i.free_address < base_q) || (pg_full >= AW'(NUM_PAGES));

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      frange_q <= range_d;
      fword_q  <= WA'(pg_full >> BitW);
      fbit_q   <= pg_full[BitW-1:0];
    end
  end

  assign sts_o.free_range = frange_q;

  // Word counter for sweeps and scans; saturates at the last word
  logic [WA-1:0] cnt_q;
  logic          chk_q;
  logic [WA-1:0] chk_idx_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      chk_q <= 1'b0;
    end else begin
      chk_q <= cmd_i.scan;
      if (cmd_i.cnt_clr) begin
        cnt_q <= '0;
      end else if (cmd_i.cnt_inc && (cnt_q != LastWord)) begin
        cnt_q <= cnt_q + WA'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    chk_idx_q <= cnt_q;
  end

  assign sts_o.cnt_last  = (cnt_q == LastWord);
  assign sts_o.chk_last  = (chk_idx_q == LastWord);
  assign sts_o.chk_valid = chk_q;

  // Init pattern for the word at the counter: 1 = free
  logic [WordW-1:0] init_word;

  always_comb begin
    logic [CW-1:0] pg;
    for (int j = 0; j < WordW; j++) begin
      pg = CW'({cnt_q, BitW'(j)});
      init_word[j] = !((pg < CW'(i_rsv_q)) ||
                       ((pg >= CW'(i_hfirst_q)) && (pg < CW'(i_hend_q))));
    end
  end

  // Bitmap memory: one read, one write per cycle, registered read data
  logic [WordW-1:0] mem [Depth];
  logic [WordW-1:0] rdata_q;
  logic             rd_en;
  logic [WA-1:0]    raddr;
  logic             we;
  logic [WA-1:0]    waddr;
  logic [WordW-1:0] wdata;

  assign rd_en = cmd_i.scan || cmd_i.rd_free;
  assign raddr = cmd_i.rd_free ? fword_q : cnt_q;

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (rd_en) begin
      rdata_q <= mem[raddr];
    end
  end

  // First free page in the checked word
  logic [WordW-1:0] masked;
  logic [BitW-1:0]  hit_bit;

  assign masked = (chk_idx_q == LastWord) ? (rdata_q & TailMask) : rdata_q;

  always_comb begin
    hit_bit = '0;
    for (int i = WordW - 1; i >= 0; i--) begin
      if (masked[i]) begin
        hit_bit = BitW'(i);
      end
    end
  end

  assign sts_o.hit = chk_q && (masked != '0);

  // Write port select
  always_comb begin
    we    = 1'b0;
    waddr = cnt_q;
    wdata = init_word;
    priority if (cmd_i.wr_init) begin
      we = 1'b1;
    end else if (cmd_i.wr_alloc) begin
      we    = 1'b1;
      waddr = chk_idx_q;
      wdata = rdata_q & ~(WordW'(1) << hit_bit);
    end else if (cmd_i.wr_free) begin
      we    = 1'b1;
      waddr = fword_q;
      wdata = rdata_q | (WordW'(1) << fbit_q);
    end
  end

  // Allocated address: base + page index * page size, modulo 2^32
  logic [AW-1:0] alloc_addr;

  assign alloc_addr = base_q + (AW'({chk_idx_q, hit_bit}) << PsShift);

  // Result register and strobe
  logic          res_valid_q;
  pba_pkg::res_t res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else begin
      res_valid_q <= cmd_i.emit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      unique case (cmd_i.res_sel)
        pba_pkg::ResOk: begin
          res_q.page_address <= '0;
          res_q.status       <= pba_pkg::StOk;
        end
        pba_pkg::ResAlloc: begin
          res_q.page_address <= alloc_addr;
          res_q.status       <= pba_pkg::StOk;
        end
        pba_pkg::ResOom: begin
          res_q.page_address <= '0;
          res_q.status       <= pba_pkg::StOom;
        end
        pba_pkg::ResRange: begin
          res_q.page_address <= '0;
          res_q.status       <= pba_pkg::StRange;
        end
        default: begin
          res_q.page_address <= '0;
          res_q.status       <= pba_pkg::StOk;
        end
      endcase
    end
  end

  assign res_o       = res_q;
  assign res_valid_o = res_valid_q;

endmodule

// File: rtl/core/page_bitmap_allocator.sv
// ----------------------------------------------------------------------------
// Page bitmap allocator
// First-fit physical page frame allocator over a free bitmap.
// ----------------------------------------------------------------------------
// A request is transferred when start is high and busy is low; every request
// gives exactly one result, shown for one cycle with res_valid_o, and the
// receiver cannot stall it. The free bitmap sits in a memory of
// ceil(NUM_PAGES/32) words of 32 pages, and that memory's single read port
// sets the timing: an allocation scans one word per cycle from word 0 and
// replies once the first word with a free page is checked (OOM once the
// last word is checked with none). A free reads and rewrites the word of
// its page (an out-of-range free replies without a memory access), a
// reinitialize sweeps every word before its reply, and an unused request
// code gets a plain ok result. After reset the block sweeps the bitmap with
// busy high and gives no result for it; configuration writes are taken at any time.
// PAGE_SIZE must be a power of two.
// ----------------------------------------------------------------------------
module page_bitmap_allocator #(
  parameter int NUM_PAGES = pba_pkg::NumPagesDef,
  parameter int PAGE_SIZE = pba_pkg::PageSizeDef
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [pba_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [pba_pkg::AddrW-1:0]   cfg_data_i,
  input  logic                        start,
  output logic                        busy,
  input  pba_pkg::req_t               req_i,
  output pba_pkg::res_t               res_o,
  output logic                        res_valid_o
);

  pba_pkg::dp_cmd_t cmd;
  pba_pkg::dp_sts_t sts;

  // Sequencer
  pba_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .sts_i  (sts),
    .cmd_o  (cmd)
  );

  // Bitmap, config and arithmetic
  pba_dp #(
    .NUM_PAGES (NUM_PAGES),
    .PAGE_SIZE (PAGE_SIZE)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .req_i       (req_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .res_o       (res_o),
    .res_valid_o (res_valid_o)
  );

endmodule

// File: tb/sv/tb_page_bitmap_allocator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Page bitmap allocator testbench
// Drives allocate, free, reinitialize and unused requests through the
// start/busy command port and checks every result strobe against an in-bench
// bitmap model or the result typed in a directed row. A directed table covers
// the corner cases, then random phases rotate the configuration registers.
// ----------------------------------------------------------------------------
module tb_page_bitmap_allocator;
  import pba_pkg::*;

  localparam int NumPages   = NumPagesDef;
  localparam int PageSize   = PageSizeDef;
  localparam int CycleLimit = 600_000;
  localparam int DrainWait  = 40;  // longer than a full OOM scan
  localparam int NumPhases  = 16;
  localparam int PhaseItems = 84;
  localparam logic [1:0] ReqUnused = 2'd3;

  typedef enum bit {RowReq, RowCfg} row_kind_e;

  typedef struct {
    row_kind_e         kind;
    req_t              item;
    logic [CfgIdxW-1:0] cfg_idx;
    logic [AddrW-1:0]  cfg_val;
    bit                typed;   // expected result written in the row
    res_t              want;
  } step_row_t;

  // DUT signals; the inputs are known from time zero
  logic               clk_i      = 1'b0;
  logic               rst_ni     = 1'b0;
  logic               cfg_we_i   = 1'b0;
  logic [CfgIdxW-1:0] cfg_idx_i  = '0;
  logic [AddrW-1:0]   cfg_data_i = '0;
  logic               start      = 1'b0;
  logic               busy;
  req_t               req_i      = '0;
  res_t               res_o;
  logic               res_valid_o;

  // Bitmap model state and mirrored registers
  bit                  page_is_free [NumPages];
  logic [AddrW-1:0]    base_cfg;
  logic [PageCfgW-1:0] rsv_cfg;
  logic [PageCfgW-1:0] hfirst_cfg;
  logic [PageCfgW-1:0] hend_cfg;

  res_t      pending_results[$];
  int        held_pages[$];      // pages handed out by allocations, for aimed frees
  step_row_t directed_steps[$];

  int cycle_cnt   = 0;
  int mismatches  = 0;
  int items_sent  = 0;
  int n_alloc_ok  = 0;
  int n_oom       = 0;
  int n_free_ok   = 0;
  int n_range     = 0;
  int n_init      = 0;
  int n_unused    = 0;

  page_bitmap_allocator u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .start       (start),
    .busy        (busy),
    .req_i       (req_i),
    .res_o       (res_o),
    .res_valid_o (res_valid_o)
  );

  // 10 ns clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CycleLimit) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_cnt,
               pending_results.size());
      $display("tb_page_bitmap_allocator: done, errors");
      $finish;
    end
  end

  function automatic void note_mismatch(string msg);
    mismatches++;
    if (mismatches <= 10) $display("[%0t] mismatch: %s", $realtime, msg);
  endfunction

  // Reinitialize: all free, then reserved low pages and heap range used
  function automatic void rebuild_map();
    int p;
    for (p = 0; p < NumPages; p++) page_is_free[p] = 1'b1;
    for (p = 0; p < int'(rsv_cfg) && p < NumPages; p++) page_is_free[p] = 1'b0;
    for (p = int'(hfirst_cfg); p < int'(hend_cfg) && p < NumPages; p++)
      page_is_free[p] = 1'b0;
  endfunction

  // Apply one request to the bitmap model and return its result
  function automatic res_t serve_request(req_t item);
    res_t             res;
    logic [AddrW-1:0] off;
    logic [AddrW-1:0] pg_idx;
    bit               found;
    int               p;
    res   = '0;
    found = 1'b0;
    case (item.req_type)
      ReqAlloc: begin
        for (p = 0; p < NumPages && !found; p++) begin
          if (page_is_free[p]) begin
            page_is_free[p]  = 1'b0;
            res.page_address = base_cfg + 32'(p * PageSize);
            found            = 1'b1;
          end
        end
        res.status = found ? StOk : StOom;
      end
      ReqFree: begin
        if (item.free_address < base_cfg) begin
          res.status = StRange;
        end else begin
          off    = item.free_address - base_cfg;
          pg_idx = off / 32'(PageSize);
          if (pg_idx < 32'(NumPages)) page_is_free[int'(pg_idx)] = 1'b1;
          else res.status = StRange;
        end
      end
      ReqInit: rebuild_map();
      default: ;
    endcase
    return res;
  endfunction

  // Random request: mostly allocations and well-aimed frees, some noise
  function automatic req_t pick_request();
    req_t        item;
    int          w;
    int          k;
    int          pg;
    logic [31:0] edges [5];
    edges[0] = base_cfg - 32'd1;
    edges[1] = base_cfg + 32'(NumPages * PageSize);
    edges[2] = base_cfg + 32'(NumPages * PageSize) - 32'd1;
    edges[3] = 32'h0;
    edges[4] = 32'hFFFF_FFFF;
    item.free_address = $urandom();
    w = $urandom_range(99);
    if (w < 44) begin
      item.req_type = ReqAlloc;
    end else if (w < 74) begin
      item.req_type = ReqFree;
      if (held_pages.size() != 0 && $urandom_range(3) != 0) begin
        k  = $urandom_range(held_pages.size() - 1);
        pg = held_pages[k];
        held_pages.delete(k);
      end else begin
        pg = $urandom_range(NumPages - 1);
      end
      item.free_address = base_cfg + 32'(pg * PageSize) + 32'($urandom_range(PageSize - 1));
    end else if (w < 82) begin
      item.req_type = ReqFree;
    end else if (w < 88) begin
      item.req_type     = ReqFree;
      item.free_address = edges[$urandom_range(4)];
    end else if (w < 94) begin
      item.req_type = ReqInit;
    end else begin
      item.req_type = ReqUnused;
    end
    return item;
  endfunction

  function automatic step_row_t req_row(logic [1:0] kind, logic [31:0] addr, bit typed,
                                        logic [31:0] page_addr, logic [1:0] status);
    step_row_t row;
    row.kind              = RowReq;
    row.item.req_type     = kind;
    row.item.free_address = addr;
    row.cfg_idx           = '0;
    row.cfg_val           = '0;
    row.typed             = typed;
    row.want.page_address = page_addr;
    row.want.status       = status;
    return row;
  endfunction

  function automatic step_row_t cfg_row(logic [CfgIdxW-1:0] idx, logic [31:0] val);
    step_row_t row;
    row         = req_row(ReqUnused, '0, 1'b0, '0, StOk);
    row.kind    = RowCfg;
    row.cfg_idx = idx;
    row.cfg_val = val;
    return row;
  endfunction

  // One request transfer; called and returns at a falling edge
  task automatic send_item(req_t item, bit typed, res_t typed_res);
    res_t pred;
    bit   idle_on;
    idle_on = (items_sent < 600 || items_sent >= 800);
    if (idle_on && $urandom_range(99) < 24) begin
      start <= 1'b0;
      repeat ($urandom_range(3) == 0 ? $urandom_range(1, 40) : $urandom_range(1, 4))
        @(negedge clk_i);
    end
    start <= 1'b1;
    req_i <= item;
    do @(posedge clk_i); while (busy !== 1'b0);
    pred = serve_request(item);
    pending_results.push_back(typed ? typed_res : pred);
    items_sent++;
    case (item.req_type)
      ReqAlloc: begin
        if (pred.status == StOk) begin
          n_alloc_ok++;
          held_pages.push_back(int'((pred.page_address - base_cfg) / 32'(PageSize)));
        end else begin
          n_oom++;
        end
      end
      ReqFree: if (pred.status == StOk) n_free_ok++; else n_range++;
      ReqInit: begin
        n_init++;
        held_pages.delete();
      end
      default: n_unused++;
    endcase
    @(negedge clk_i);
  endtask

  // Hold off requests until every result is back and the block is idle
  task automatic drain();
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    while (busy !== 1'b0) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic write_cfg(logic [CfgIdxW-1:0] idx, logic [31:0] val);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    case (idx)
      CfgBaseAddr:  base_cfg   = val;
      CfgRsvPages:  rsv_cfg    = val[PageCfgW-1:0];
      CfgHeapFirst: hfirst_cfg = val[PageCfgW-1:0];
      CfgHeapEnd:   hend_cfg   = val[PageCfgW-1:0];
      default: ;
    endcase
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    @(negedge clk_i);
  endtask

  // Result checker: one strobe per result, no back-pressure
  always @(posedge clk_i) begin : check_results
    res_t want;
    if (rst_ni && res_valid_o !== 1'b0) begin
      if (pending_results.size() == 0) begin
        note_mismatch($sformatf("result with none pending: addr %h status %0d",
                                res_o.page_address, res_o.status));
      end else begin
        want = pending_results.pop_front();
        if (res_o.page_address !== want.page_address)
          note_mismatch($sformatf("page_address exp %h got %h",
                                  want.page_address, res_o.page_address));
        if (res_o.status !== want.status)
          note_mismatch($sformatf("status exp %0d got %0d", want.status, res_o.status));
      end
    end
  end

  initial begin : stimulus
    step_row_t   row;
    logic [31:0] cb;
    logic [31:0] cr;
    logic [31:0] cf;
    logic [31:0] ce;
    int          ph;
    int          k;

    // Reset config and its bitmap
    base_cfg   = BaseAddrRst;
    rsv_cfg    = RsvPagesRst;
    hfirst_cfg = HeapFirstRst;
    hend_cfg   = HeapEndRst;
    rebuild_map();

    // Directed: default map has pages 0..511 used, first free is 512
    directed_steps.push_back(req_row(ReqAlloc, 32'h0, 1, 32'h0030_0000, StOk));
    directed_steps.push_back(req_row(ReqFree, 32'h0030_0000, 1, 32'h0, StOk));
    directed_steps.push_back(req_row(ReqAlloc, 32'hFFFF_FFFF, 1, 32'h0030_0000, StOk));
    directed_steps.push_back(req_row(ReqFree, 32'h0000_0000, 1, 32'h0, StRange));
    directed_steps.push_back(req_row(ReqFree, 32'hFFFF_FFFF, 1, 32'h0, StRange));
    directed_steps.push_back(req_row(ReqFree, 32'h0050_0000, 1, 32'h0, StRange));
    directed_steps.push_back(req_row(ReqFree, 32'h004F_FFFF, 0, 32'h0, StOk));
    // free of a reserved page, with an in-page offset
    directed_steps.push_back(req_row(ReqFree, 32'h0010_0ABC, 0, 32'h0, StOk));
    directed_steps.push_back(req_row(ReqAlloc, 32'h0, 1, 32'h0010_0000, StOk));
    directed_steps.push_back(req_row(ReqUnused, 32'hFFFF_FFFF, 1, 32'h0, StOk));
    directed_steps.push_back(req_row(ReqInit, 32'hFFFF_FFFF, 1, 32'h0, StOk));
    directed_steps.push_back(req_row(ReqAlloc, 32'h0, 1, 32'h0030_0000, StOk));
    // everything reserved: out of memory until a page is freed
    directed_steps.push_back(cfg_row(CfgRsvPages, 32'd1024));
    directed_steps.push_back(req_row(ReqInit, 32'h0, 1, 32'h0, StOk));
    directed_steps.push_back(req_row(ReqAlloc, 32'h0, 1, 32'h0, StOom));
    directed_steps.push_back(req_row(ReqFree, 32'h0010_5000, 0, 32'h0, StOk));
    directed_steps.push_back(req_row(ReqAlloc, 32'h0, 1, 32'h0010_5000, StOk));
    directed_steps.push_back(req_row(ReqAlloc, 32'h0, 1, 32'h0, StOom));
    // top-of-range base
    directed_steps.push_back(cfg_row(CfgBaseAddr, 32'hFFFF_FFFF));
    directed_steps.push_back(req_row(ReqFree, 32'hFFFF_FFFF, 0, 32'h0, StOk));
    directed_steps.push_back(req_row(ReqAlloc, 32'h0, 1, 32'hFFFF_FFFF, StOk));
    // heap covering the whole map
    directed_steps.push_back(cfg_row(CfgBaseAddr, 32'h0));
    directed_steps.push_back(cfg_row(CfgRsvPages, 32'd0));
    directed_steps.push_back(cfg_row(CfgHeapFirst, 32'd0));
    directed_steps.push_back(cfg_row(CfgHeapEnd, 32'd1024));
    directed_steps.push_back(req_row(ReqInit, 32'h0, 1, 32'h0, StOk));
    directed_steps.push_back(req_row(ReqAlloc, 32'h0, 1, 32'h0, StOom));
    // reversed heap bounds mark nothing
    directed_steps.push_back(cfg_row(CfgHeapFirst, 32'd1024));
    directed_steps.push_back(cfg_row(CfgHeapEnd, 32'd0));
    directed_steps.push_back(req_row(ReqInit, 32'h0, 1, 32'h0, StOk));
    directed_steps.push_back(req_row(ReqAlloc, 32'h0, 1, 32'h0, StOk));
    directed_steps.push_back(req_row(ReqFree, 32'h0040_0000, 1, 32'h0, StRange));

    // Reset
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (directed_steps[i]) begin
      row = directed_steps[i];
      if (row.kind == RowCfg) begin
        drain();
        write_cfg(row.cfg_idx, row.cfg_val);
      end else begin
        send_item(row.item, row.typed, row.want);
      end
    end

    // Random phases, each with its own register setting
    for (ph = 0; ph < NumPhases; ph++) begin
      drain();
      cb = $urandom();
      cr = $urandom_range(1024);
      cf = $urandom_range(1024);
      ce = $urandom_range(1024);
      case (ph % 8)
        0: begin
          cb = BaseAddrRst;
          cr = RsvPagesRst;
          cf = HeapFirstRst;
          ce = HeapEndRst;
        end
        1: begin
          cb = 32'h0;
          cr = 32'd0;
          cf = 32'd0;
          ce = 32'd0;
        end
        2: cr = 32'd1024;
        3: begin
          cb = 32'hFFFF_FFFF;
          cr = $urandom_range(960, 1024);
          cf = 32'd0;
          ce = 32'd0;
        end
        4: cb = $urandom() & 32'hFFFF_F000;
        5: begin
          cr = 32'd0;
          cf = 32'd0;
          ce = 32'd1024;
        end
        6: begin
          cr = $urandom_range(64);
          cf = 32'd1024;
          ce = 32'd0;
        end
        default: begin
          cb = 32'hFFFF_F000;
          cr = $urandom_range(900, 1024);
          ce = 32'd1024;
        end
      endcase
      write_cfg(CfgBaseAddr, cb);
      write_cfg(CfgRsvPages, cr);
      write_cfg(CfgHeapFirst, cf);
      write_cfg(CfgHeapEnd, ce);
      if ($urandom_range(9) != 0) send_item('{ReqInit, $urandom()}, 1'b0, '0);
      for (k = 0; k < PhaseItems; k++) begin
        if ($urandom_range(99) == 0) drain();
        send_item(pick_request(), 1'b0, '0);
      end
    end

    // Wind down
    drain();
    repeat (DrainWait) @(posedge clk_i);
    if (pending_results.size() != 0)
      note_mismatch($sformatf("%0d results never arrived", pending_results.size()));

    $display("covered %0d requests over %0d register settings: %0d allocations, %0d OOM",
             items_sent, NumPhases, n_alloc_ok, n_oom);
    $display("  %0d frees, %0d out-of-range frees, %0d reinits, %0d unused codes; %0d mismatches",
             n_free_ok, n_range, n_init, n_unused, mismatches);
    if (mismatches == 0) begin
      $display("tb_page_bitmap_allocator: done, clean");
    end else begin
      $display("tb_page_bitmap_allocator: done, errors");
    end
    $finish;
  end

endmodule
